/* sv/pcap_stream_record_checker_top_defines.svh */
// assertion macros shared by the capture-file record checker
`ifndef PCAP_STREAM_RECORD_CHECKER_TOP_DEFINES_SVH
`define PCAP_STREAM_RECORD_CHECKER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk and held off during rst
`define PSRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and held off during rst
`define PSRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/psrc_pkg.sv */
// types, constants and field helpers of the capture-file record checker
package psrc_pkg;

  // header sizes in bytes and the last count value of each
  localparam int FILE_HDR_BYTES = 24;
  localparam int REC_HDR_SHORT = 16;
  localparam int REC_HDR_LONG = 24;
  localparam logic [4:0] FILE_HDR_LAST = 5'(FILE_HDR_BYTES - 1);
  localparam logic [4:0] REC_SHORT_LAST = 5'(REC_HDR_SHORT - 1);
  localparam logic [4:0] REC_LONG_LAST = 5'(REC_HDR_LONG - 1);

  // payload bytes taken per record at most
  localparam logic [15:0] MAX_FRAME_BYTES = 16'hffff;

  // supported format version
  localparam logic [15:0] SUPPORTED_MAJOR = 16'd2;
  localparam logic [15:0] SUPPORTED_MINOR = 16'd4;

  // magic words in native order, code is position + 1 (position + 6 when byte-swapped)
  localparam int NUM_MAGIC = 5;
  localparam logic [31:0] MAGIC_WORDS [NUM_MAGIC] = '{
    32'ha1b2c3d4, 32'ha1b2cd34, 32'ha1b234cd, 32'ha12b3c4d, 32'ha1b23c4d
  };
  localparam logic [3:0] MAGIC_UNKNOWN = 4'd0;
  localparam logic [3:0] MAGIC_SWAP_BASE = 4'd6;
  localparam logic [3:0] MAGIC_LONG_NATIVE = 4'd2;
  localparam logic [3:0] MAGIC_LONG_SWAPPED = 4'd7;

  // configuration register map
  localparam int PADDR_W = 3;
  localparam logic REG_MAX_CAP_IDX = 1'b0;
  localparam logic [31:0] MAX_CAP_RESET = 32'd262144;

  // note bits
  localparam int NOTE_BACKWARDS = 0;
  localparam int NOTE_TOO_BIG = 1;

  typedef enum logic [2:0] {
    KIND_FILE_HDR    = 3'd0,
    KIND_PACKET      = 3'd1,
    KIND_TOO_SMALL   = 3'd2,
    KIND_BAD_VERSION = 3'd3,
    KIND_TRUNCATED   = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_FILE = 4'b0001,
    PH_REC  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_STOP = 4'b1000
  } phase_t;

  typedef logic [FILE_HDR_BYTES-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [3:0]  magic_kind;
    logic [31:0] packet_number;
    logic [31:0] orig_len;
    logic [31:0] cap_len;
    logic [31:0] ts_sec;
    logic [31:0] ts_frac;
    logic [31:0] rec_index;
    logic [15:0] rec_protocol;
    logic [7:0]  rec_pkt_type;
    logic [30:0] word_sum;
    logic [1:0]  note;
  } result_t;

  function automatic logic [31:0] swap32(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // little-endian 32-bit field at off, byte-swapped for a big-endian file
  function automatic logic [31:0] get32(hdr_bytes_t h, logic [4:0] off, logic sw);
    logic [31:0] v;
    v = {h[off + 5'd3], h[off + 5'd2], h[off + 5'd1], h[off]};
    return sw ? swap32(v) : v;
  endfunction

  function automatic logic [15:0] get16(hdr_bytes_t h, logic [4:0] off, logic sw);
    return sw ? {h[off], h[off + 5'd1]} : {h[off + 5'd1], h[off]};
  endfunction

  // magic word to format code, zero when unknown
  function automatic logic [3:0] magic_decode(logic [31:0] m);
    logic [3:0] code;
    code = MAGIC_UNKNOWN;
    for (int i = 0; i < NUM_MAGIC; i++) begin
      if (m == MAGIC_WORDS[i]) begin
        code = 4'(i + 1);
      end else if (m == swap32(MAGIC_WORDS[i])) begin
        code = 4'(i) + MAGIC_SWAP_BASE;
      end
    end
    return code;
  endfunction

endpackage

/* sv/psrc_if.sv */
// stream interfaces: file bytes in, record results out

interface psrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface psrc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [3:0]  magic_kind;
  logic [31:0] packet_number;
  logic [31:0] orig_len;
  logic [31:0] cap_len;
  logic [31:0] ts_sec;
  logic [31:0] ts_frac;
  logic [31:0] rec_index;
  logic [15:0] rec_protocol;
  logic [7:0]  rec_pkt_type;
  logic [30:0] word_sum;
  logic [1:0]  note;

  modport source (
    output valid, output result_kind, output magic_kind, output packet_number,
    output orig_len, output cap_len, output ts_sec, output ts_frac, output rec_index,
    output rec_protocol, output rec_pkt_type, output word_sum, output note,
    input ready
  );
  modport sink (
    input valid, input result_kind, input magic_kind, input packet_number,
    input orig_len, input cap_len, input ts_sec, input ts_frac, input rec_index,
    input rec_protocol, input rec_pkt_type, input word_sum, input note,
    output ready
  );
endinterface

/* sv/pcap_stream_record_checker_top.sv */
// top level of the capture-file record checker
// Takes a capture file one byte per transaction (end_of_file marks the end and resets
// the parser) and gives one result per file header, record, or error. A byte is taken
// every clock cycle while the result stream keeps up; each byte passes an input register,
// combinational parse logic and the result register. The result register is the only
// buffer on the output side: while it holds an untaken result, at most one more byte is
// taken. No memory needs clearing after reset. max_capture_len sits at APB byte address
// 0 and must only be written while the stream is idle.
module pcap_stream_record_checker_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psrc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  psrc_in_if.sink                      byte_stream,
  psrc_out_if.source                   result_stream
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              in_eof;
  logic              step;
  logic              slot_free;
  logic              res_valid;
  logic [31:0]       max_capture_len;
  psrc_pkg::result_t res, res_q;

  // configuration port
  psrc_cfg_regs u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_capture_len (max_capture_len)
  );

  // input register, advances when the result slot is free
  assign step = in_full && slot_free;
  assign byte_stream.ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_stream.valid && byte_stream.ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      in_byte <= byte_stream.data_byte;
      in_eof  <= byte_stream.end_of_file;
    end
  end

  // parser
  psrc_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .data_byte       (in_byte),
    .end_of_file     (in_eof),
    .max_capture_len (max_capture_len),
    .res_valid       (res_valid),
    .res             (res)
  );

  // result register
  psrc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .res_in    (res),
    .take      (result_stream.ready),
    .out_valid (result_stream.valid),
    .res_out   (res_q),
    .slot_free (slot_free)
  );

  // result stream payload
  assign result_stream.result_kind   = res_q.result_kind;
  assign result_stream.magic_kind    = res_q.magic_kind;
  assign result_stream.packet_number = res_q.packet_number;
  assign result_stream.orig_len      = res_q.orig_len;
  assign result_stream.cap_len       = res_q.cap_len;
  assign result_stream.ts_sec        = res_q.ts_sec;
  assign result_stream.ts_frac       = res_q.ts_frac;
  assign result_stream.rec_index     = res_q.rec_index;
  assign result_stream.rec_protocol  = res_q.rec_protocol;
  assign result_stream.rec_pkt_type  = res_q.rec_pkt_type;
  assign result_stream.word_sum      = res_q.word_sum;
  assign result_stream.note          = res_q.note;

endmodule

/* sv/psrc_cfg_regs.sv */
// apb configuration register: capture length limit
module psrc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psrc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [31:0]                  max_capture_len
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      max_capture_len <= psrc_pkg::MAX_CAP_RESET;
    end else if (wr_en && paddr[2] == psrc_pkg::REG_MAX_CAP_IDX) begin
      max_capture_len <= pwdata;
    end
  end

  // read back, unmapped addresses read zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == psrc_pkg::REG_MAX_CAP_IDX) begin
      prdata = max_capture_len;
    end
  end

endmodule

/* sv/psrc_parser.sv */
// byte-level capture-file parser: header decode, record checks, payload sum
`include "pcap_stream_record_checker_top_defines.svh"

module psrc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              end_of_file,
  input  logic [31:0]       max_capture_len,
  output logic              res_valid,
  output psrc_pkg::result_t res
);

  // control state
  psrc_pkg::phase_t phase, phase_next;
  logic [4:0]  cnt, cnt_next;
  logic [3:0]  magic, magic_next;
  logic        long_hdr, long_hdr_next;
  logic [31:0] snap_len, snap_len_next;
  logic [31:0] pkt_count, pkt_count_next;
  logic [31:0] prev_sec, prev_sec_next;
  logic [31:0] prev_frac, prev_frac_next;
  logic [30:0] run_sum, run_sum_next;
  logic [15:0] pay_left, pay_left_next;
  logic [7:0]  held, held_next;

  // header bytes and the record waiting for its payload
  psrc_pkg::hdr_bytes_t hdr, hv;
  logic        hdr_we, pend_we;
  logic [31:0] pend_orig, pend_cap, pend_sec, pend_frac, pend_idx;
  logic [15:0] pend_proto;
  logic [7:0]  pend_ptype;
  logic [1:0]  pend_note;

  // file header decode
  logic [3:0]  fh_magic;
  logic        fh_swap;
  logic [15:0] fh_major, fh_minor;
  logic [31:0] fh_snap, fh_link;
  logic        fh_bad;

  // record header decode
  logic        rh_swap;
  logic [31:0] rh_sec, rh_frac, rh_cap, rh_orig, rh_idx;
  logic [15:0] rh_proto;
  logic [7:0]  rh_ptype;
  logic        rh_big, rh_ts_valid, rh_back;
  logic [1:0]  rh_note;
  logic [15:0] rh_pay_len;
  logic [4:0]  rec_last;

  // payload accumulate
  logic [30:0] addend, sum_calc;

  // header view with the byte of this cycle merged in
  always_comb begin
    for (int i = 0; i < psrc_pkg::FILE_HDR_BYTES; i++) begin
      hv[i] = (5'(i) == cnt) ? data_byte : hdr[i];
    end
  end

  // file header fields
  assign fh_magic = psrc_pkg::magic_decode({hv[3], hv[2], hv[1], hv[0]});
  assign fh_swap  = fh_magic >= psrc_pkg::MAGIC_SWAP_BASE;
  assign fh_major = psrc_pkg::get16(hv, 5'd4, fh_swap);
  assign fh_minor = psrc_pkg::get16(hv, 5'd6, fh_swap);
  assign fh_snap  = psrc_pkg::get32(hv, 5'd16, fh_swap);
  assign fh_link  = psrc_pkg::get32(hv, 5'd20, fh_swap);
  assign fh_bad   = (fh_major != psrc_pkg::SUPPORTED_MAJOR) ||
                    (fh_minor != psrc_pkg::SUPPORTED_MINOR);

  // record header fields
  assign rh_swap  = magic >= psrc_pkg::MAGIC_SWAP_BASE;
  assign rh_sec   = psrc_pkg::get32(hv, 5'd0, rh_swap);
  assign rh_frac  = psrc_pkg::get32(hv, 5'd4, rh_swap);
  assign rh_cap   = psrc_pkg::get32(hv, 5'd8, rh_swap);
  assign rh_orig  = psrc_pkg::get32(hv, 5'd12, rh_swap);
  assign rh_idx   = long_hdr ? psrc_pkg::get32(hv, 5'd16, rh_swap) : '0;
  assign rh_proto = long_hdr ? psrc_pkg::get16(hv, 5'd20, rh_swap) : '0;
  assign rh_ptype = long_hdr ? hv[22] : '0;
  assign rec_last = long_hdr ? psrc_pkg::REC_LONG_LAST : psrc_pkg::REC_SHORT_LAST;

  // record checks: size limit and timestamp order
  assign rh_big = (snap_len < rh_cap) || (!long_hdr && rh_cap > max_capture_len);
  assign rh_ts_valid = (prev_sec != '0) && !prev_sec[31] &&
                       (prev_frac != '0) && !prev_frac[31];
  assign rh_back = (rh_sec == prev_sec) ? (rh_frac < prev_frac) : (rh_sec < prev_sec);
  always_comb begin
    rh_note = '0;
    rh_note[psrc_pkg::NOTE_TOO_BIG] = rh_big;
    rh_note[psrc_pkg::NOTE_BACKWARDS] = rh_ts_valid && rh_back;
  end
  assign rh_pay_len = (rh_cap > 32'(psrc_pkg::MAX_FRAME_BYTES)) ?
                      psrc_pkg::MAX_FRAME_BYTES : rh_cap[15:0];

  // even byte adds alone (final odd byte), odd byte completes a word
  assign addend = cnt[0] ? {15'd0, data_byte, held} : {23'd0, data_byte};
  assign sum_calc = run_sum + addend;

  // next state and result
  always_comb begin
    phase_next     = phase;
    cnt_next       = cnt;
    magic_next     = magic;
    long_hdr_next  = long_hdr;
    snap_len_next  = snap_len;
    pkt_count_next = pkt_count;
    prev_sec_next  = prev_sec;
    prev_frac_next = prev_frac;
    run_sum_next   = run_sum;
    pay_left_next  = pay_left;
    held_next      = held;
    hdr_we         = 1'b0;
    pend_we        = 1'b0;
    res_valid      = 1'b0;
    res            = '0;

    if (end_of_file) begin
      // end of file: report by phase, then back to the reset state
      if (phase == psrc_pkg::PH_FILE) begin
        res_valid = 1'b1;
        res.result_kind = psrc_pkg::KIND_TOO_SMALL;
      end else if (phase == psrc_pkg::PH_PAY) begin
        res_valid = 1'b1;
        res.result_kind   = psrc_pkg::KIND_TRUNCATED;
        res.magic_kind    = magic;
        res.packet_number = pkt_count;
        res.orig_len      = pend_orig;
        res.cap_len       = pend_cap;
        res.ts_sec        = pend_sec;
        res.ts_frac       = pend_frac;
        res.rec_index     = pend_idx;
        res.rec_protocol  = pend_proto;
        res.rec_pkt_type  = pend_ptype;
        res.note          = pend_note;
      end
      phase_next     = psrc_pkg::PH_FILE;
      cnt_next       = '0;
      magic_next     = psrc_pkg::MAGIC_UNKNOWN;
      long_hdr_next  = 1'b0;
      snap_len_next  = '0;
      pkt_count_next = '0;
      prev_sec_next  = '0;
      prev_frac_next = '0;
      run_sum_next   = '0;
      pay_left_next  = '0;
      held_next      = '0;
    end else begin
      case (phase)
        psrc_pkg::PH_FILE: begin
          hdr_we = 1'b1;
          cnt_next = cnt + 5'd1;
          if (cnt == psrc_pkg::FILE_HDR_LAST) begin
            cnt_next = '0;
            magic_next = fh_magic;
            long_hdr_next = (fh_magic == psrc_pkg::MAGIC_LONG_NATIVE) ||
                            (fh_magic == psrc_pkg::MAGIC_LONG_SWAPPED);
            snap_len_next = fh_snap;
            res_valid = 1'b1;
            res.result_kind = fh_bad ? psrc_pkg::KIND_BAD_VERSION : psrc_pkg::KIND_FILE_HDR;
            res.magic_kind = fh_magic;
            res.orig_len = fh_link;
            res.cap_len = fh_snap;
            phase_next = fh_bad ? psrc_pkg::PH_STOP : psrc_pkg::PH_REC;
          end
        end
        psrc_pkg::PH_REC: begin
          hdr_we = 1'b1;
          cnt_next = cnt + 5'd1;
          if (cnt == rec_last) begin
            cnt_next = '0;
            pend_we = 1'b1;
            prev_sec_next = rh_sec;
            prev_frac_next = rh_frac;
            pkt_count_next = pkt_count + 32'd1;
            pay_left_next = rh_pay_len;
            run_sum_next = '0;
            held_next = '0;
            if (rh_pay_len == '0) begin
              // empty payload: the record is done at its header
              res_valid = 1'b1;
              res.result_kind   = psrc_pkg::KIND_PACKET;
              res.magic_kind    = magic;
              res.packet_number = pkt_count + 32'd1;
              res.orig_len      = rh_orig;
              res.cap_len       = rh_cap;
              res.ts_sec        = rh_sec;
              res.ts_frac       = rh_frac;
              res.rec_index     = rh_idx;
              res.rec_protocol  = rh_proto;
              res.rec_pkt_type  = rh_ptype;
              res.note          = rh_note;
              phase_next = rh_note[psrc_pkg::NOTE_TOO_BIG] ? psrc_pkg::PH_STOP :
                                                             psrc_pkg::PH_REC;
            end else begin
              phase_next = psrc_pkg::PH_PAY;
            end
          end
        end
        psrc_pkg::PH_PAY: begin
          cnt_next = cnt + 5'd1;
          run_sum_next = cnt[0] ? sum_calc : run_sum;
          held_next = cnt[0] ? held : data_byte;
          pay_left_next = pay_left - 16'd1;
          if (pay_left == 16'd1) begin
            cnt_next = '0;
            res_valid = 1'b1;
            res.result_kind   = psrc_pkg::KIND_PACKET;
            res.magic_kind    = magic;
            res.packet_number = pkt_count;
            res.orig_len      = pend_orig;
            res.cap_len       = pend_cap;
            res.ts_sec        = pend_sec;
            res.ts_frac       = pend_frac;
            res.rec_index     = pend_idx;
            res.rec_protocol  = pend_proto;
            res.rec_pkt_type  = pend_ptype;
            res.word_sum      = sum_calc;
            res.note          = pend_note;
            phase_next = pend_note[psrc_pkg::NOTE_TOO_BIG] ? psrc_pkg::PH_STOP :
                                                             psrc_pkg::PH_REC;
          end
        end
        psrc_pkg::PH_STOP: begin
          // bytes ignored until end of file
        end
        default: begin
          phase_next = psrc_pkg::PH_FILE;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= psrc_pkg::PH_FILE;
      cnt       <= '0;
      magic     <= psrc_pkg::MAGIC_UNKNOWN;
      long_hdr  <= 1'b0;
      snap_len  <= '0;
      pkt_count <= '0;
      prev_sec  <= '0;
      prev_frac <= '0;
      run_sum   <= '0;
      pay_left  <= '0;
      held      <= '0;
    end else if (step) begin
      phase     <= phase_next;
      cnt       <= cnt_next;
      magic     <= magic_next;
      long_hdr  <= long_hdr_next;
      snap_len  <= snap_len_next;
      pkt_count <= pkt_count_next;
      prev_sec  <= prev_sec_next;
      prev_frac <= prev_frac_next;
      run_sum   <= run_sum_next;
      pay_left  <= pay_left_next;
      held      <= held_next;
    end
  end

  // header byte store
  always_ff @(posedge clk) begin
    if (step && hdr_we) begin
      hdr[cnt] <= data_byte;
    end
  end

  // pending record fields
  always_ff @(posedge clk) begin
    if (step && pend_we) begin
      pend_orig  <= rh_orig;
      pend_cap   <= rh_cap;
      pend_sec   <= rh_sec;
      pend_frac  <= rh_frac;
      pend_idx   <= rh_idx;
      pend_proto <= rh_proto;
      pend_ptype <= rh_ptype;
      pend_note  <= rh_note;
    end
  end

  // checks
  `PSRC_ASSERT_NOW(a_stop_silent, step && !end_of_file && phase == psrc_pkg::PH_STOP, !res_valid, "result while stopped")
  `PSRC_ASSERT_NOW(a_pay_nonzero, phase == psrc_pkg::PH_PAY, pay_left != 16'd0, "payload phase with nothing left")
  `PSRC_ASSERT_NOW(a_hdr_count, phase == psrc_pkg::PH_FILE || phase == psrc_pkg::PH_REC, cnt <= psrc_pkg::FILE_HDR_LAST, "header count out of range")
  `PSRC_ASSERT_NEXT(a_eof_clears, step && end_of_file, phase == psrc_pkg::PH_FILE && cnt == 5'd0 && pkt_count == 32'd0, "state not cleared after end of file")
  `PSRC_ASSERT_NEXT(a_hdr_to_rec, step && res_valid && res.result_kind == psrc_pkg::KIND_FILE_HDR, phase == psrc_pkg::PH_REC, "good file header did not start records")

endmodule

/* sv/psrc_out_reg.sv */
// result register between the parser and the result stream
module psrc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  psrc_pkg::result_t res_in,
  input  logic              take,
  output logic              out_valid,
  output psrc_pkg::result_t res_out,
  output logic              slot_free
);

  logic valid_next;

  assign slot_free = !out_valid || take;

  // hold until the transaction completes, reload in the same cycle
  always_comb begin
    valid_next = out_valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* dv/psrc_result_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the capture-file record checker: byte-level parser predictor and result compare
module psrc_result_checker
  import psrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  psrc_in_if                 byte_stream,
  psrc_out_if                result_stream,
  output int                 fail_count,
  output int                 results_pending
);

  localparam logic [PADDR_W-1:0] MAX_CAP_ADDR = PADDR_W'(4 * REG_MAX_CAP_IDX);

  // predictor state
  logic [31:0] max_cap;
  phase_t      ph;
  int          hdr_cnt;
  logic [7:0]  hdr [FILE_HDR_BYTES];
  logic [3:0]  magic;
  logic        long_rec;
  logic [31:0] snap;
  logic [31:0] rec_count;
  logic [31:0] prior_sec;
  logic [31:0] prior_frac;
  logic [30:0] pay_sum;
  logic [15:0] pay_left;
  logic        pay_odd;
  logic [7:0]  low_byte;
  result_t     open_rec;

  result_t     results_due [$];
  int          fails;

  function automatic void clear_parser();
    ph = PH_FILE;
    hdr_cnt = 0;
    magic = MAGIC_UNKNOWN;
    long_rec = 1'b0;
    snap = '0;
    rec_count = '0;
    prior_sec = '0;
    prior_frac = '0;
    pay_sum = '0;
    pay_left = '0;
    pay_odd = 1'b0;
    low_byte = '0;
    open_rec = '0;
  endfunction

  function automatic logic [31:0] byte_rev(logic [31:0] v);
    return {<<8{v}};
  endfunction

  // header fields are little-endian unless the magic says the file is swapped
  function automatic logic [31:0] hdr_word(int off);
    logic [31:0] v;
    v = {hdr[off + 3], hdr[off + 2], hdr[off + 1], hdr[off]};
    return (magic >= MAGIC_SWAP_BASE) ? byte_rev(v) : v;
  endfunction

  function automatic logic [15:0] hdr_half(int off);
    return (magic >= MAGIC_SWAP_BASE) ? {hdr[off], hdr[off + 1]} : {hdr[off + 1], hdr[off]};
  endfunction

  function automatic bit close_file_header(output result_t r);
    logic [31:0] m;
    logic [15:0] major;
    logic [15:0] minor;
    m = {hdr[3], hdr[2], hdr[1], hdr[0]};
    magic = MAGIC_UNKNOWN;
    for (int i = 0; i < NUM_MAGIC; i++) begin
      if (m == MAGIC_WORDS[i]) begin
        magic = 4'(i + 1);
      end else if (m == byte_rev(MAGIC_WORDS[i])) begin
        magic = MAGIC_SWAP_BASE + 4'(i);
      end
    end
    long_rec = (magic == MAGIC_LONG_NATIVE) || (magic == MAGIC_LONG_SWAPPED);
    major = hdr_half(4);
    minor = hdr_half(6);
    snap = hdr_word(16);
    hdr_cnt = 0;
    r = '0;
    r.magic_kind = magic;
    r.orig_len = hdr_word(20);
    r.cap_len = snap;
    if (major != SUPPORTED_MAJOR || minor != SUPPORTED_MINOR) begin
      ph = PH_STOP;
      r.result_kind = KIND_BAD_VERSION;
    end else begin
      ph = PH_REC;
      r.result_kind = KIND_FILE_HDR;
    end
    return 1'b1;
  endfunction

  function automatic bit close_record(output result_t r);
    if (pay_odd) begin
      pay_sum = pay_sum + 31'(low_byte);
    end
    r = open_rec;
    r.result_kind = KIND_PACKET;
    r.magic_kind = magic;
    r.packet_number = rec_count;
    r.word_sum = pay_sum;
    ph = open_rec.note[NOTE_TOO_BIG] ? PH_STOP : PH_REC;
    hdr_cnt = 0;
    pay_odd = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit close_rec_header(output result_t r);
    logic [31:0] sec;
    logic [31:0] frac;
    logic [31:0] cap;
    sec = hdr_word(0);
    frac = hdr_word(4);
    cap = hdr_word(8);
    open_rec = '0;
    open_rec.ts_sec = sec;
    open_rec.ts_frac = frac;
    open_rec.cap_len = cap;
    open_rec.orig_len = hdr_word(12);
    if (long_rec) begin
      open_rec.rec_index = hdr_word(16);
      open_rec.rec_protocol = hdr_half(20);
      open_rec.rec_pkt_type = hdr[22];
    end
    // the capture limit register only applies to 16-byte record headers
    if (snap < cap || (!long_rec && cap > max_cap)) begin
      open_rec.note[NOTE_TOO_BIG] = 1'b1;
    end
    // ordering is tested only when both previous values are positive and below 2^31
    if (prior_sec != 0 && prior_sec <= 32'h7fff_ffff && prior_frac != 0 &&
        prior_frac <= 32'h7fff_ffff) begin
      if (sec == prior_sec ? frac < prior_frac : sec < prior_sec) begin
        open_rec.note[NOTE_BACKWARDS] = 1'b1;
      end
    end
    prior_sec = sec;
    prior_frac = frac;
    rec_count = rec_count + 32'd1;
    pay_left = (cap > 32'(MAX_FRAME_BYTES)) ? MAX_FRAME_BYTES : cap[15:0];
    pay_sum = '0;
    low_byte = '0;
    pay_odd = 1'b0;
    hdr_cnt = 0;
    r = '0;
    if (pay_left == 0) begin
      return close_record(r);
    end
    ph = PH_PAY;
    return 1'b0;
  endfunction

  // one byte or end-of-file marker; returns 1 when a result is due
  function automatic bit parse_byte(logic [7:0] b, logic eof, output result_t r);
    bit got;
    got = 1'b0;
    r = '0;
    if (eof) begin
      if (ph == PH_FILE) begin
        r.result_kind = KIND_TOO_SMALL;
        got = 1'b1;
      end else if (ph == PH_PAY) begin
        r = open_rec;
        r.result_kind = KIND_TRUNCATED;
        r.magic_kind = magic;
        r.packet_number = rec_count;
        r.word_sum = '0;
        got = 1'b1;
      end
      clear_parser();
      return got;
    end
    case (ph)
      PH_FILE: begin
        hdr[hdr_cnt] = b;
        hdr_cnt++;
        if (hdr_cnt >= FILE_HDR_BYTES) begin
          got = close_file_header(r);
        end
      end
      PH_REC: begin
        hdr[hdr_cnt] = b;
        hdr_cnt++;
        if (hdr_cnt >= (long_rec ? REC_HDR_LONG : REC_HDR_SHORT)) begin
          got = close_rec_header(r);
        end
      end
      PH_PAY: begin
        if (!pay_odd) begin
          low_byte = b;
        end else begin
          pay_sum = pay_sum + 31'({b, low_byte});
        end
        pay_odd = ~pay_odd;
        pay_left = pay_left - 16'd1;
        if (pay_left == 0) begin
          got = close_record(r);
        end
      end
      default: begin
      end
    endcase
    return got;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, seen);
      fails++;
    end
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      max_cap = MAX_CAP_RESET;
      clear_parser();
      results_due.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == MAX_CAP_ADDR) begin
        max_cap = pwdata;
      end
      // input transaction
      if (byte_stream.valid && byte_stream.ready) begin
        if (parse_byte(byte_stream.data_byte, byte_stream.end_of_file, want)) begin
          results_due.push_back(want);
        end
      end
      // output transaction
      if (result_stream.valid && result_stream.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with none expected: expected nothing, actual kind %0d",
                   $time, result_stream.result_kind);
          fails++;
        end else begin
          want = results_due.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(result_stream.result_kind));
          check_field("magic_kind", 32'(want.magic_kind), 32'(result_stream.magic_kind));
          check_field("packet_number", want.packet_number, result_stream.packet_number);
          check_field("orig_len", want.orig_len, result_stream.orig_len);
          check_field("cap_len", want.cap_len, result_stream.cap_len);
          check_field("ts_sec", want.ts_sec, result_stream.ts_sec);
          check_field("ts_frac", want.ts_frac, result_stream.ts_frac);
          check_field("rec_index", want.rec_index, result_stream.rec_index);
          check_field("rec_protocol", 32'(want.rec_protocol), 32'(result_stream.rec_protocol));
          check_field("rec_pkt_type", 32'(want.rec_pkt_type), 32'(result_stream.rec_pkt_type));
          check_field("word_sum", 32'(want.word_sum), 32'(result_stream.word_sum));
          check_field("note", 32'(want.note), 32'(result_stream.note));
        end
      end
    end
    fail_count <= fails;
    results_pending <= results_due.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// testbench top: capture-file stimulus, register writes, flow control and verdict
module tb_top;
  import psrc_pkg::*;

  localparam logic [PADDR_W-1:0] MAX_CAP_ADDR = PADDR_W'(4 * REG_MAX_CAP_IDX);
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_SETTING = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  psrc_in_if  byte_ch ();
  psrc_out_if res_ch ();

  int          fail_count;
  int          results_pending;
  bit          calm = 1'b0;
  int          hold_req = 0;
  int          quiet = 0;
  int          bytes_sent = 0;
  logic [31:0] max_cap_now = MAX_CAP_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pcap_stream_record_checker_top uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .byte_stream   (byte_ch),
    .result_stream (res_ch)
  );

  psrc_result_checker chk (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .byte_stream     (byte_ch),
    .result_stream   (res_ch),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side flow control, with an occasional long hold-off
  initial begin : ready_drive
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (calm) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= 22);
      end
    end
  end

  // one input transaction, entered and left at a falling edge
  task automatic send_item(logic [7:0] d, logic e);
    while (!calm && $urandom_range(99) < 22) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= d;
    byte_ch.end_of_file <= e;
    do @(posedge clk); while (!byte_ch.ready);
    @(negedge clk);
  endtask

  task automatic put_byte(logic [7:0] d);
    send_item(d, 1'b0);
    bytes_sent++;
  endtask

  task automatic put_eof();
    send_item(8'($urandom), 1'b1);
    bytes_sent++;
  endtask

  // bytes after a stop are ignored by the parser
  task automatic junk();
    repeat ($urandom_range(0, 4)) send_item(8'($urandom), 1'b0);
  endtask

  task automatic put32(logic [31:0] v, logic big);
    for (int i = 0; i < 4; i++) begin
      put_byte(big ? v[31 - 8 * i -: 8] : v[8 * i +: 8]);
    end
  endtask

  task automatic put16(logic [15:0] v, logic big);
    put_byte(big ? v[15:8] : v[7:0]);
    put_byte(big ? v[7:0] : v[15:8]);
  endtask

  task automatic put_file_header(int code, logic [15:0] major, logic [15:0] minor,
                                 logic [31:0] snap, logic [31:0] link);
    logic big;
    big = (code >= MAGIC_SWAP_BASE);
    if (code == MAGIC_UNKNOWN) begin
      put32($urandom, 1'b0);
    end else if (big) begin
      put32(MAGIC_WORDS[code - MAGIC_SWAP_BASE], 1'b1);
    end else begin
      put32(MAGIC_WORDS[code - 1], 1'b0);
    end
    put16(major, big);
    put16(minor, big);
    put32($urandom, big);
    put32($urandom, big);
    put32(snap, big);
    put32(link, big);
  endtask

  task automatic put_rec_header(logic big, logic long_rec, logic [31:0] sec, logic [31:0] frac,
                                logic [31:0] cap, logic [31:0] orig, logic [31:0] idx,
                                logic [15:0] proto, logic [7:0] ptype);
    put32(sec, big);
    put32(frac, big);
    put32(cap, big);
    put32(orig, big);
    if (long_rec) begin
      put32(idx, big);
      put16(proto, big);
      put_byte(ptype);
      put_byte(8'($urandom));
    end
  endtask

  task automatic put_payload(int n);
    repeat (n) put_byte(8'($urandom));
  endtask

  // wait for all expected results, then for the pipeline to drain
  task automatic settle();
    byte_ch.valid <= 1'b0;
    wait (results_pending == 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= MAX_CAP_ADDR;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    max_cap_now = v;
  endtask

  // header errors, byte orders, timestamp order, stops, truncation, oversized capture
  task automatic directed_files();
    int codes [6] = '{3, 4, 5, 8, 9, 10};
    logic [31:0] cap;
    // empty file and short headers
    put_eof();
    repeat (10) put_byte(8'($urandom));
    put_eof();
    repeat (FILE_HDR_BYTES - 1) put_byte(8'hff);
    put_eof();
    // unsupported versions, native and swapped
    put_file_header(1, SUPPORTED_MAJOR, 16'd3, 32'd1000, 32'd1);
    junk();
    put_eof();
    put_file_header(6, 16'd1, SUPPORTED_MINOR, 32'd1000, 32'd1);
    put_eof();
    // standard file: zero capture length, backwards timestamps, out-of-range previous values
    put_file_header(1, SUPPORTED_MAJOR, SUPPORTED_MINOR, MAX_CAP_RESET, 32'd1);
    put_rec_header(1'b0, 1'b0, 32'd100, 32'd500, 32'd0, 32'd0, '0, '0, '0);
    put_rec_header(1'b0, 1'b0, 32'd100, 32'd400, 32'd5, 32'hffff_ffff, '0, '0, '0);
    repeat (5) put_byte(8'h00);
    put_rec_header(1'b0, 1'b0, 32'd99, 32'd900, 32'd4, 32'd4, '0, '0, '0);
    repeat (4) put_byte(8'hff);
    put_rec_header(1'b0, 1'b0, 32'h8000_0000, 32'd1, 32'd2, 32'd2, '0, '0, '0);
    put_payload(2);
    put_rec_header(1'b0, 1'b0, 32'd5, 32'd5, 32'd1, 32'd1, '0, '0, '0);
    put_payload(1);
    // partial record header then end of file
    put_payload(7);
    put_eof();
    // swapped long records with field extremes, then one larger than snap
    put_file_header(7, SUPPORTED_MAJOR, SUPPORTED_MINOR, 32'd64, 32'hffff_ffff);
    put_rec_header(1'b1, 1'b1, 32'd1, 32'd2, 32'd3, 32'd0, 32'hffff_ffff, 16'hffff, 8'hff);
    put_payload(3);
    put_rec_header(1'b1, 1'b1, 32'd1, 32'd1, 32'd70, 32'd70, 32'd0, 16'h0000, 8'h00);
    put_payload(70);
    junk();
    put_eof();
    // native long record cut short
    put_file_header(2, SUPPORTED_MAJOR, SUPPORTED_MINOR, 32'd1000, 32'd0);
    put_rec_header(1'b0, 1'b1, 32'd7, 32'd7, 32'd10, 32'd10, $urandom, 16'($urandom),
                   8'($urandom));
    put_payload(4);
    put_eof();
    // unknown magic is read as little-endian with short records
    put_file_header(0, SUPPORTED_MAJOR, SUPPORTED_MINOR, 32'd1000, 32'd1);
    put_rec_header(1'b0, 1'b0, 32'd3, 32'd3, 32'd2, 32'd2, '0, '0, '0);
    put_payload(2);
    put_eof();
    // remaining formats, zero snap length on one
    foreach (codes[i]) begin
      cap = $urandom_range(1, 9);
      put_file_header(codes[i], SUPPORTED_MAJOR, SUPPORTED_MINOR,
                      (codes[i] == 3) ? 32'd0 : 32'd5000, codes[i]);
      put_rec_header(codes[i] >= MAGIC_SWAP_BASE, 1'b0, $urandom, $urandom, cap, $urandom,
                     '0, '0, '0);
      put_payload(cap);
      put_eof();
    end
    // capture length over the frame limit, cut short inside the payload
    put_file_header(1, SUPPORTED_MAJOR, SUPPORTED_MINOR, 32'hffff_ffff, 32'd1);
    put_rec_header(1'b0, 1'b0, 32'd10, 32'd10, 32'd65540, 32'd65540, '0, '0, '0);
    put_payload(6);
    put_eof();
  endtask

  // capture limit of 16 on short records of both orders, long records exempt
  task automatic max_cap_files();
    put_file_header(1, SUPPORTED_MAJOR, SUPPORTED_MINOR, 32'd1000, 32'd1);
    put_rec_header(1'b0, 1'b0, 32'd1, 32'd1, 32'd16, 32'd16, '0, '0, '0);
    put_payload(16);
    put_rec_header(1'b0, 1'b0, 32'd2, 32'd1, 32'd17, 32'd17, '0, '0, '0);
    put_payload(17);
    junk();
    put_eof();
    put_file_header(6, SUPPORTED_MAJOR, SUPPORTED_MINOR, 32'd1000, 32'd1);
    put_rec_header(1'b1, 1'b0, 32'd1, 32'd1, 32'd17, 32'd17, '0, '0, '0);
    put_payload(17);
    put_eof();
    put_file_header(2, SUPPORTED_MAJOR, SUPPORTED_MINOR, 32'd1000, 32'd1);
    put_rec_header(1'b0, 1'b1, 32'd1, 32'd1, 32'd40, 32'd40, $urandom, 16'($urandom),
                   8'($urandom));
    put_payload(40);
    put_eof();
  endtask

  // one random file, mostly well formed
  task automatic random_file();
    int          code;
    int          nrec;
    int          sel;
    int          hdr_len;
    logic        big;
    logic        long_rec;
    logic [15:0] major;
    logic [15:0] minor;
    logic [31:0] snap;
    logic [31:0] sec;
    logic [31:0] frac;
    logic [31:0] cap;
    sel = $urandom_range(99);
    if (sel < 5) begin
      repeat ($urandom_range(0, FILE_HDR_BYTES - 1)) put_byte(8'($urandom));
      put_eof();
      return;
    end
    code = $urandom_range(0, 10);
    big = (code >= MAGIC_SWAP_BASE);
    long_rec = (code == MAGIC_LONG_NATIVE) || (code == MAGIC_LONG_SWAPPED);
    hdr_len = long_rec ? REC_HDR_LONG : REC_HDR_SHORT;
    major = SUPPORTED_MAJOR;
    minor = SUPPORTED_MINOR;
    if (sel < 11) begin
      case ($urandom_range(2))
        0: major = 16'($urandom);
        1: minor = 16'($urandom);
        default: begin
          major = 16'($urandom_range(0, 3));
          minor = 16'($urandom_range(0, 5));
        end
      endcase
    end
    case ($urandom_range(3))
      0: snap = $urandom_range(8, 64);
      1: snap = MAX_CAP_RESET;
      2: snap = 32'hffff_ffff;
      default: snap = $urandom;
    endcase
    put_file_header(code, major, minor, snap, $urandom);
    if (major != SUPPORTED_MAJOR || minor != SUPPORTED_MINOR) begin
      junk();
      put_eof();
      return;
    end
    nrec = $urandom_range(0, 6);
    sec = $urandom_range(1, 2000);
    frac = $urandom_range(1, 999999);
    for (int i = 0; i < nrec; i++) begin
      // timestamps mostly move forward
      case ($urandom_range(19))
        0, 1: sec = sec - 32'd1;
        2: frac = frac - 32'd1;
        3: sec = 32'h8000_0000 | $urandom;
        4: frac = 32'd0;
        default: begin
          sec = sec + $urandom_range(0, 1);
          frac = $urandom_range(0, 999999);
        end
      endcase
      case ($urandom_range(9))
        0: cap = 32'd0;
        1: cap = (snap < 200) ? snap + $urandom_range(1, 3) : $urandom_range(1, 24);
        2: cap = $urandom_range(25, 120);
        3: cap = (max_cap_now < 200) ? max_cap_now + 32'd1 : $urandom_range(1, 24);
        default: cap = $urandom_range(1, 24);
      endcase
      // end of file inside a record header
      if ($urandom_range(19) == 0) begin
        repeat ($urandom_range(1, hdr_len - 1)) put_byte(8'($urandom));
        put_eof();
        return;
      end
      put_rec_header(big, long_rec, sec, frac, cap, $urandom, $urandom, 16'($urandom),
                     8'($urandom));
      // end of file inside a payload
      if (cap > 0 && $urandom_range(11) == 0) begin
        put_payload($urandom_range(0, int'(cap) - 1));
        put_eof();
        return;
      end
      put_payload(int'(cap));
      if (cap > snap || (!long_rec && cap > max_cap_now)) begin
        junk();
        put_eof();
        return;
      end
    end
    put_eof();
  endtask

  task automatic random_phase(logic [31:0] limit, bit no_idle, bit press);
    int target;
    reg_write(limit);
    calm = no_idle;
    if (press) begin
      hold_req++;
    end
    target = bytes_sent + ITEMS_PER_SETTING;
    while (bytes_sent < target) begin
      random_file();
    end
    settle();
    calm = 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.end_of_file = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    directed_files();
    settle();
    reg_write(32'd16);
    max_cap_files();
    settle();
    random_phase(32'd1, 1'b0, 1'b0);
    random_phase(32'hffff_ffff, 1'b1, 1'b0);
    random_phase($urandom_range(8, 64), 1'b0, 1'b1);
    random_phase($urandom, 1'b0, 1'b0);
    if (fail_count == 0 && results_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
